// ----- hw/rtl/swrd_pkg.sv -----
package swrd_pkg;

  localparam logic [31:0] SyncWord    = 32'hEEEE_EEEE;
  localparam logic [2:0]  WindowBytes = 3'd4;
  localparam logic [2:0]  TimeBytes   = 3'd4;
  localparam logic [2:0]  LastByteIdx = 3'd7;

  typedef struct packed {
    logic [31:0] rec_time;
    logic [31:0] rec_id;
    logic [31:0] rec_count;
  } rec_t;

endpackage

// ----- hw/rtl/sync_word_record_deframer.sv -----
// Sync word record deframer. Takes one stream byte per cycle while the
// output is not held, and hunts for the sync word EE EE EE EE, sliding a
// byte at a time; the 8 bytes after it are a little-endian 32-bit time and
// 32-bit id. Records whose id matches skip_id are dropped; others come out
// with a wrapping count of emitted records. Each result passes through the
// input register, then the result register, and the input keeps flowing
// while a result waits as long as the result register is taken. Write
// skip_id only while the block is idle.
module sync_word_record_deframer import swrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] record_time_o,
  output logic [31:0] record_id_o,
  output logic [31:0] record_count_o
);

  logic [31:0] skip_id_q;
  logic        item_vld;
  logic [7:0]  item_byte;
  logic        out_free;
  logic        advance;
  logic        emit;
  rec_t        rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_id_q <= '0;
    end else if (cfg_valid_i) begin
      skip_id_q <= cfg_data_i;
    end
  end

  assign advance = item_vld && out_free;

  swrd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .item_vld_o  (item_vld),
    .item_byte_o (item_byte)
  );

  swrd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (item_byte),
    .skip_id_i (skip_id_q),
    .emit_o    (emit),
    .rec_o     (rec)
  );

  swrd_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (emit),
    .rec_i          (rec),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_time_o  (record_time_o),
    .record_id_o    (record_id_o),
    .record_count_o (record_count_o)
  );

endmodule

// ----- hw/rtl/swrd_in_stage.sv -----
module swrd_in_stage import swrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       advance_i,
  output logic       item_vld_o,
  output logic [7:0] item_byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_ready_o = !vld_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign vld_d      = take || (vld_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= data_byte_i;
    end
  end

  assign item_vld_o  = vld_q;
  assign item_byte_o = byte_q;

endmodule

// ----- hw/rtl/swrd_core.sv -----
module swrd_core import swrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] skip_id_i,
  output logic        emit_o,
  output rec_t        rec_o
);

  logic [31:0] window_q, window_d;
  logic [2:0]  fill_q, fill_d;
  logic        in_rec_q, in_rec_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] time_q, time_d;
  logic [23:0] id_q, id_d;
  logic [31:0] total_q, total_d;
  logic [31:0] win_shift;
  logic [2:0]  fill_inc;
  logic [31:0] full_id;

  assign win_shift = {byte_i, window_q[31:8]};
  assign fill_inc  = (fill_q < WindowBytes) ? fill_q + 3'd1 : fill_q;
  assign full_id   = {byte_i, id_q};

  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    in_rec_d = in_rec_q;
    idx_d    = idx_q;
    time_d   = time_q;
    id_d     = id_q;
    total_d  = total_q;
    emit_o   = 1'b0;
    if (step_i) begin
      if (!in_rec_q) begin
        window_d = win_shift;
        fill_d   = fill_inc;
        if (fill_inc >= WindowBytes && win_shift == SyncWord) begin
          window_d = '0;
          fill_d   = '0;
          in_rec_d = 1'b1;
          idx_d    = '0;
          time_d   = '0;
          id_d     = '0;
        end
      end else if (idx_q < TimeBytes) begin
        time_d = {byte_i, time_q[31:8]};
        idx_d  = idx_q + 3'd1;
      end else if (idx_q < LastByteIdx) begin
        id_d  = {byte_i, id_q[23:8]};
        idx_d = idx_q + 3'd1;
      end else begin
        // record done, hunt restarts on fresh bytes
        window_d = '0;
        fill_d   = '0;
        in_rec_d = 1'b0;
        idx_d    = '0;
        time_d   = '0;
        id_d     = '0;
        if (full_id != skip_id_i) begin
          emit_o  = 1'b1;
          total_d = total_q + 32'd1;
        end
      end
    end
  end

  assign rec_o.rec_time  = time_q;
  assign rec_o.rec_id    = full_id;
  assign rec_o.rec_count = total_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      in_rec_q <= 1'b0;
      idx_q    <= '0;
      time_q   <= '0;
      id_q     <= '0;
      total_q  <= '0;
    end else begin
      window_q <= window_d;
      fill_q   <= fill_d;
      in_rec_q <= in_rec_d;
      idx_q    <= idx_d;
      time_q   <= time_d;
      id_q     <= id_d;
      total_q  <= total_d;
    end
  end

endmodule

// ----- hw/rtl/swrd_out_stage.sv -----
module swrd_out_stage import swrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  rec_t        rec_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] record_time_o,
  output logic [31:0] record_id_o,
  output logic [31:0] record_count_o
);

  logic vld_q, vld_d;
  rec_t rec_q;

  assign free_o = !vld_q || out_ready_i;
  assign vld_d  = load_i || (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o    = vld_q;
  assign record_time_o  = rec_q.rec_time;
  assign record_id_o    = rec_q.rec_id;
  assign record_count_o = rec_q.rec_count;

endmodule
